### hdl/pr4d_pkg.sv
// ----------------------------------------------------------------------------
// pr4d_pkg
// Shared constants, types and the arctangent table of the 4-D plane rotation.
// ----------------------------------------------------------------------------
`default_nettype none

package pr4d_pkg;

  // Point geometry
  localparam int DIM     = 4;   // active axes, 2..4
  localparam int NCOORD  = 4;   // coordinate fields on the ports
  localparam int COORD_W = 24;
  localparam int AXIS_W  = 2;
  localparam int ANGLE_W = 16;

  // CORDIC datapath
  localparam int CORDIC_STEPS = 16;  // 8..24
  localparam int TABLE_LEN    = 24;
  localparam int GUARD        = 8;
  localparam int PRE_W        = COORD_W + 1;   // pre-rotated pair, negation safe
  localparam int XW           = 36;            // holds pair gain times CORDIC gain
  localparam int ZW           = 32;            // residual angle, 2^-32 turn

  // Gain correction: floor((v * GAIN + 2^37) / 2^38)
  localparam int GAIN_W   = 30;
  localparam int LO_W     = 18;
  localparam int HI_W     = XW - LO_W;
  localparam int PH_W     = HI_W + GAIN_W + 1;
  localparam int PL_W     = LO_W + 1 + GAIN_W + 1;
  localparam int SUM_W    = PH_W + LO_W + 1;
  localparam int G_SHIFT  = 38;
  localparam int R_W      = SUM_W - G_SHIFT;
  localparam logic signed [GAIN_W:0] GAIN_INV = 31'sd652032875;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_PLANE_FIRST  = 2'd0,
    REG_PLANE_SECOND = 2'd1,
    REG_TURN_ANGLE   = 2'd2
  } pr4d_reg_e;

  typedef logic signed [COORD_W-1:0] pr4d_coord_t;

  typedef struct packed {
    logic [AXIS_W-1:0]  plane_first;
    logic [AXIS_W-1:0]  plane_second;
    logic [ANGLE_W-1:0] turn_angle;
  } pr4d_cfg_t;

  // One item inside the rotation pipeline
  typedef struct packed {
    logic                       rot;
    logic [AXIS_W-1:0]          a;
    logic [AXIS_W-1:0]          b;
    pr4d_coord_t [NCOORD-1:0]   c;
    logic signed [XW-1:0]       x;
    logic signed [XW-1:0]       y;
    logic signed [ZW-1:0]       z;
  } pr4d_stage_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] t;
    unique case (i)
      0:       t = 32'sh20000000;
      1:       t = 32'sh12E4051D;
      2:       t = 32'sh09FB385B;
      3:       t = 32'sh051111D4;
      4:       t = 32'sh028B0D43;
      5:       t = 32'sh0145D7E1;
      6:       t = 32'sh00A2F61E;
      7:       t = 32'sh00517C55;
      8:       t = 32'sh0028BE53;
      9:       t = 32'sh00145F2E;
      10:      t = 32'sh000A2F98;
      11:      t = 32'sh000517CC;
      12:      t = 32'sh00028BE6;
      13:      t = 32'sh000145F3;
      14:      t = 32'sh0000A2F9;
      15:      t = 32'sh0000517C;
      16:      t = 32'sh000028BE;
      17:      t = 32'sh0000145F;
      18:      t = 32'sh00000A2F;
      19:      t = 32'sh00000517;
      20:      t = 32'sh0000028B;
      21:      t = 32'sh00000145;
      22:      t = 32'sh000000A2;
      23:      t = 32'sh00000051;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

### hdl/pr4d_ifs.sv
// ----------------------------------------------------------------------------
// pr4d point channels
// Valid/ready channels for input points and rotated results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pr4d_in_if;
  import pr4d_pkg::*;
  logic        valid;
  logic        ready;
  pr4d_coord_t coord_0;
  pr4d_coord_t coord_1;
  pr4d_coord_t coord_2;
  pr4d_coord_t coord_3;

  modport source (output valid, coord_0, coord_1, coord_2, coord_3, input ready);
  modport sink   (input valid, coord_0, coord_1, coord_2, coord_3, output ready);
endinterface

interface pr4d_out_if;
  import pr4d_pkg::*;
  logic        valid;
  logic        ready;
  pr4d_coord_t rotated_0;
  pr4d_coord_t rotated_1;
  pr4d_coord_t rotated_2;
  pr4d_coord_t rotated_3;
  logic        clipped;

  modport source (output valid, rotated_0, rotated_1, rotated_2, rotated_3, clipped,
                  input ready);
  modport sink   (input valid, rotated_0, rotated_1, rotated_2, rotated_3, clipped,
                  output ready);
endinterface

`default_nettype wire

### hdl/pr4d_cfg.sv
// ----------------------------------------------------------------------------
// pr4d_cfg
// APB register file: rotation plane axes and turn angle.
// ----------------------------------------------------------------------------
`default_nettype none

module pr4d_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pr4d_pkg::ADDR_W-1:0]  paddr,
  input  logic [pr4d_pkg::DATA_W-1:0]  pwdata,
  output logic [pr4d_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output pr4d_pkg::pr4d_cfg_t          cfg_o
);
  import pr4d_pkg::*;

  pr4d_cfg_t cfg_q;
  pr4d_reg_e sel;
  logic      wr_en;

  assign sel    = pr4d_reg_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.plane_first  <= AXIS_W'(0);
      cfg_q.plane_second <= AXIS_W'(1);
      cfg_q.turn_angle   <= '0;
    end else if (wr_en) begin
      unique case (sel)
        REG_PLANE_FIRST:  cfg_q.plane_first  <= pwdata[AXIS_W-1:0];
        REG_PLANE_SECOND: cfg_q.plane_second <= pwdata[AXIS_W-1:0];
        REG_TURN_ANGLE:   cfg_q.turn_angle   <= pwdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_PLANE_FIRST:  prdata = DATA_W'(cfg_q.plane_first);
      REG_PLANE_SECOND: prdata = DATA_W'(cfg_q.plane_second);
      REG_TURN_ANGLE:   prdata = DATA_W'(cfg_q.turn_angle);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/pr4d_front.sv
// ----------------------------------------------------------------------------
// pr4d_front
// Accept points, decide rotate or pass, apply the exact quarter-turn step.
// ----------------------------------------------------------------------------
`default_nettype none

module pr4d_front (
  pr4d_in_if.sink                 pnt,
  input  pr4d_pkg::pr4d_cfg_t     cfg_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output pr4d_pkg::pr4d_stage_t   job_o
);
  import pr4d_pkg::*;

  localparam logic [ANGLE_W-1:0] EIGHTH = ANGLE_W'(1) << (ANGLE_W - 3);

  pr4d_coord_t [NCOORD-1:0]  c;
  logic [ANGLE_W-1:0]        shifted;
  logic [1:0]                quad;
  logic signed [ANGLE_W-1:0] resid;
  logic signed [PRE_W-1:0]   ea, eb, xs, ys;

  assign pnt.ready = !q_full_i;
  assign push_o    = pnt.valid && pnt.ready;

  always_comb begin
    c[0] = pnt.coord_0;
    c[1] = pnt.coord_1;
    c[2] = pnt.coord_2;
    c[3] = pnt.coord_3;
    // axes beyond the dimension read as zero
    for (int k = 0; k < NCOORD; k++) begin
      if (k >= DIM) c[k] = '0;
    end
  end

  // residual angle in [-1/8, 1/8) turn, quadrant done exactly
  assign shifted = cfg_i.turn_angle + EIGHTH;
  assign quad    = shifted[ANGLE_W-1:ANGLE_W-2];
  assign resid   = signed'({2'b00, shifted[ANGLE_W-3:0]}) - signed'(EIGHTH);

  assign ea = PRE_W'(c[cfg_i.plane_first]);
  assign eb = PRE_W'(c[cfg_i.plane_second]);

  always_comb begin
    unique case (quad)
      2'd1:    begin xs = -eb; ys = ea;  end
      2'd2:    begin xs = -ea; ys = -eb; end
      2'd3:    begin xs = eb;  ys = -ea; end
      default: begin xs = ea;  ys = eb;  end
    endcase
  end

  always_comb begin
    job_o.rot = (cfg_i.plane_first != cfg_i.plane_second)
             && (int'(cfg_i.plane_first) < DIM) && (int'(cfg_i.plane_second) < DIM);
    job_o.a   = cfg_i.plane_first;
    job_o.b   = cfg_i.plane_second;
    job_o.c   = c;
    job_o.x   = XW'(xs) <<< GUARD;
    job_o.y   = XW'(ys) <<< GUARD;
    job_o.z   = ZW'(resid) <<< (ZW - ANGLE_W);
  end

endmodule

`default_nettype wire

### hdl/pr4d_queue.sv
// ----------------------------------------------------------------------------
// pr4d_queue
// Short FIFO that decouples the front from the rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module pr4d_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  pr4d_pkg::pr4d_stage_t   push_data_i,
  output logic                    full_o,
  input  logic                    pop_i,
  output logic                    valid_o,
  output pr4d_pkg::pr4d_stage_t   head_o
);
  import pr4d_pkg::*;

  pr4d_stage_t       slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (int'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= (int'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

### hdl/pr4d_back.sv
// ----------------------------------------------------------------------------
// pr4d_back
// Unrolled CORDIC pipeline, split gain multiply, saturation and output word.
// ----------------------------------------------------------------------------
`default_nettype none

module pr4d_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  pr4d_pkg::pr4d_stage_t   q_head_i,
  output logic                    q_pop_o,
  pr4d_out_if.source              res
);
  import pr4d_pkg::*;

  localparam logic signed [SUM_W-1:0] RND   = SUM_W'(1) <<< (G_SHIFT - 1);
  localparam logic signed [R_W-1:0]   R_MAX = R_W'((1 <<< (COORD_W - 1)) - 1);
  localparam logic signed [R_W-1:0]   R_MIN = -R_W'(1 <<< (COORD_W - 1));

  typedef struct packed {
    logic                       rot;
    logic [AXIS_W-1:0]          a;
    logic [AXIS_W-1:0]          b;
    pr4d_coord_t [NCOORD-1:0]   c;
    logic signed [PH_W-1:0]     pha;
    logic signed [PL_W-1:0]     pla;
    logic signed [PH_W-1:0]     phb;
    logic signed [PL_W-1:0]     plb;
  } mul_t;

  typedef struct packed {
    pr4d_coord_t [NCOORD-1:0]   r;
    logic                       clipped;
  } result_t;

  function automatic pr4d_stage_t micro_rot(pr4d_stage_t s, int i);
    logic signed [XW-1:0] dx, dy;
    pr4d_stage_t          o;
    o  = s;
    dx = s.y >>> i;
    dy = s.x >>> i;
    if (s.z[ZW-1]) begin
      o.x = s.x + dx;
      o.y = s.y - dy;
      o.z = s.z + atan_turn(i);
    end else begin
      o.x = s.x - dx;
      o.y = s.y + dy;
      o.z = s.z - atan_turn(i);
    end
    return o;
  endfunction

  // {clip, value}
  function automatic logic [COORD_W:0] finish(logic signed [PH_W-1:0] ph,
                                              logic signed [PL_W-1:0] pl);
    logic signed [SUM_W-1:0] s;
    logic signed [R_W-1:0]   r;
    logic [COORD_W:0]        o;
    s = (SUM_W'(ph) <<< LO_W) + SUM_W'(pl) + RND;
    r = s[SUM_W-1:G_SHIFT];
    if (r > R_MAX)      o = {1'b1, R_MAX[COORD_W-1:0]};
    else if (r < R_MIN) o = {1'b1, R_MIN[COORD_W-1:0]};
    else                o = {1'b0, r[COORD_W-1:0]};
    return o;
  endfunction

  logic                 en;
  pr4d_stage_t          st_q [CORDIC_STEPS+1];
  pr4d_stage_t          st_d [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0] st_vld_q;
  mul_t                 mul_q, mul_d;
  logic                 mul_vld_q;
  result_t              out_q, out_d;
  logic                 out_vld_q;
  logic [COORD_W:0]     fa, fb;

  // whole pipeline advances unless a finished word is waiting
  assign en      = !out_vld_q || res.ready;
  assign q_pop_o = en && q_valid_i;

  always_comb begin
    st_d[0] = q_head_i;
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      st_d[k+1] = micro_rot(st_q[k], k);
    end
  end

  always_comb begin
    logic signed [HI_W-1:0] ha, hb;
    logic signed [LO_W:0]   la, lb;
    ha = st_q[CORDIC_STEPS].x[XW-1:LO_W];
    hb = st_q[CORDIC_STEPS].y[XW-1:LO_W];
    la = signed'({1'b0, st_q[CORDIC_STEPS].x[LO_W-1:0]});
    lb = signed'({1'b0, st_q[CORDIC_STEPS].y[LO_W-1:0]});
    mul_d.rot = st_q[CORDIC_STEPS].rot;
    mul_d.a   = st_q[CORDIC_STEPS].a;
    mul_d.b   = st_q[CORDIC_STEPS].b;
    mul_d.c   = st_q[CORDIC_STEPS].c;
    mul_d.pha = PH_W'(ha) * PH_W'(GAIN_INV);
    mul_d.phb = PH_W'(hb) * PH_W'(GAIN_INV);
    mul_d.pla = PL_W'(la) * PL_W'(GAIN_INV);
    mul_d.plb = PL_W'(lb) * PL_W'(GAIN_INV);
  end

  assign fa = finish(mul_q.pha, mul_q.pla);
  assign fb = finish(mul_q.phb, mul_q.plb);

  always_comb begin
    out_d.r       = mul_q.c;
    out_d.clipped = mul_q.rot && (fa[COORD_W] || fb[COORD_W]);
    for (int k = 0; k < NCOORD; k++) begin
      if (mul_q.rot && mul_q.a == AXIS_W'(k)) out_d.r[k] = fa[COORD_W-1:0];
      if (mul_q.rot && mul_q.b == AXIS_W'(k)) out_d.r[k] = fb[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q  <= st_d;
      mul_q <= mul_d;
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q  <= '0;
      mul_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      st_vld_q  <= {st_vld_q[CORDIC_STEPS-1:0], q_valid_i};
      mul_vld_q <= st_vld_q[CORDIC_STEPS];
      out_vld_q <= mul_vld_q;
    end
  end

  assign res.valid     = out_vld_q;
  assign res.rotated_0 = out_q.r[0];
  assign res.rotated_1 = out_q.r[1];
  assign res.rotated_2 = out_q.r[2];
  assign res.rotated_3 = out_q.r[3];
  assign res.clipped   = out_q.clipped;

endmodule

`default_nettype wire

### hdl/plane_rotation_4d_point_top.sv
// Path: a point accepted on the input passes the queue, the CORDIC stage
//   registers, the multiply register and the output register to its result word.
// Throughput: one point per cycle; the unrolled CORDIC pipeline takes a new
//   point every cycle and stalls as a whole only while a result word waits.
// Reset: rst_ni clears every valid bit, the queue and the registers to
//   plane_first 0, plane_second 1, turn_angle 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
// plane_rotation_4d_point_top
// Rotates a 4-D Q15.8 point in the plane of two configured axes.
// ----------------------------------------------------------------------------
`default_nettype none

module plane_rotation_4d_point_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pr4d_pkg::ADDR_W-1:0]  paddr,
  input  logic [pr4d_pkg::DATA_W-1:0]  pwdata,
  output logic [pr4d_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  // point words in, rotated words out
  pr4d_in_if.sink                      pnt_i,
  pr4d_out_if.source                   rot_o
);
  import pr4d_pkg::*;

  pr4d_cfg_t   cfg;
  pr4d_stage_t job;
  pr4d_stage_t head;
  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        pop;

  // Register file. The user must write only while the block is idle; the block
  // itself does not enforce it, and the front reads the registers directly.
  pr4d_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Front: take a point word, classify it (rotate the selected pair or pass
  // it through), fold the angle into an exact quarter turn plus a residual.
  pr4d_front u_front (
    .pnt      (pnt_i),
    .cfg_i    (cfg),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (job)
  );

  // Queue: hold classified points so the front keeps accepting while the
  // back end is held by a waiting result word.
  pr4d_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  // Back: one CORDIC micro-rotation per stage, then the gain multiply split
  // into two partial products, then round, saturate and register the word.
  pr4d_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (head),
    .q_pop_o   (pop),
    .res       (rot_o)
  );

endmodule

`default_nettype wire

### hdl/pr4d_chk.sv
// ----------------------------------------------------------------------------
// pr4d_chk
// Port-level checks of the rotation block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pr4d_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [pr4d_pkg::COORD_W-1:0] out_r0_i,
  input logic [pr4d_pkg::COORD_W-1:0] out_r1_i,
  input logic [pr4d_pkg::COORD_W-1:0] out_r2_i,
  input logic [pr4d_pkg::COORD_W-1:0] out_r3_i,
  input logic                        out_clip_i
);
  import pr4d_pkg::*;

  // queue, CORDIC stages, multiply stage and output word
  localparam int CAP   = QDEPTH + CORDIC_STEPS + 3;
  localparam int CNT_W = $clog2(CAP + 2);

  logic [CNT_W-1:0] pend_q;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_r0_i) && $stable(out_r1_i)
      && $stable(out_r2_i) && $stable(out_r3_i) && $stable(out_clip_i))
    else $error("stalled result word changed");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != '0)
    else $error("result word without an accepted point");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(pend_q) <= CAP)
    else $error("more points in flight than the pipeline holds");

endmodule

bind plane_rotation_4d_point_top pr4d_chk u_pr4d_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pnt_i.valid),
  .in_ready_i  (pnt_i.ready),
  .out_valid_i (rot_o.valid),
  .out_ready_i (rot_o.ready),
  .out_r0_i    (rot_o.rotated_0),
  .out_r1_i    (rot_o.rotated_1),
  .out_r2_i    (rot_o.rotated_2),
  .out_r3_i    (rot_o.rotated_3),
  .out_clip_i  (rot_o.clipped)
);

`default_nettype wire

### test/tb_plane_rotation_4d_point_top.sv
// ----------------------------------------------------------------------------
// tb_plane_rotation_4d_point_top
// Self-checking bench for the 4-D plane rotation. Points enter on a
// valid/ready channel with random gaps. Rotated words leave under random
// back-pressure and are compared field by field with a bit-exact CORDIC
// prediction. Plane axes and angle are reprogrammed over APB between batches.
// ----------------------------------------------------------------------------
module tb_plane_rotation_4d_point_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pr4d_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int LATENCY       = CORDIC_STEPS + 3;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_GAP       = 10;
  localparam int LONG_HOLD     = 150;
  localparam int NUM_BATCHES   = 14;
  localparam int BATCH_POINTS  = 74;
  localparam int BURST_BATCH   = 6;   // sender floods while the sink holds off
  localparam int FREE_BATCH    = 9;   // neither side idles
  localparam int STEPS         = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  // Unmapped register slot: writes there must leave the plane untouched
  localparam logic [AXIS_W-1:0] REG_SPARE = 2'd3;

  localparam pr4d_coord_t C_MAX = 24'sh7FFFFF;
  localparam pr4d_coord_t C_MIN = 24'sh800000;
  localparam longint      GAIN_K = 64'sd652032875;   // 1/K of CORDIC, Q30

  // atan(2^-i) in units of 2^-32 turn
  localparam longint ATAN_TURN [0:TABLE_LEN-1] = '{
    64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
  };

  typedef pr4d_coord_t [0:NCOORD-1] point_t;

  typedef struct packed {
    point_t crd;
    logic   clip;
  } rot_word_t;

  // One directed row: plane setting, point, and whether the word must come
  // back as the point itself (axes equal, or a zero point)
  typedef struct packed {
    pr4d_cfg_t cfg;
    point_t    pt;
    logic      unchanged;
  } point_case_t;

  localparam int NUM_DIRECTED = 20;
  localparam point_case_t DIRECTED [0:NUM_DIRECTED-1] = '{
    '{'{2'd0, 2'd1, 16'h0000}, '{24'sd0, 24'sd0, 24'sd0, 24'sd0}, 1'b1},
    '{'{2'd0, 2'd1, 16'h0000}, '{C_MAX, C_MIN, C_MAX, C_MIN}, 1'b0},
    '{'{2'd0, 2'd1, 16'h0000}, '{-24'sd1, 24'sd1, 24'sd256, -24'sd256}, 1'b0},
    '{'{2'd0, 2'd1, 16'h4000}, '{24'sd256, 24'sd0, 24'sd7, -24'sd7}, 1'b0},
    '{'{2'd1, 2'd0, 16'h4000}, '{C_MIN, C_MAX, 24'sd0, 24'sd0}, 1'b0},
    '{'{2'd0, 2'd1, 16'h2000}, '{C_MAX, C_MAX, 24'sd1, -24'sd1}, 1'b0},
    '{'{2'd0, 2'd1, 16'h2000}, '{C_MIN, C_MIN, C_MIN, C_MAX}, 1'b0},
    '{'{2'd2, 2'd3, 16'h8000}, '{24'sd12345, -24'sd54321, C_MIN, C_MIN}, 1'b0},
    '{'{2'd2, 2'd3, 16'h8000}, '{24'sd0, 24'sd0, C_MAX, C_MAX}, 1'b0},
    '{'{2'd3, 2'd0, 16'hC000}, '{C_MAX, 24'sd5, 24'sd6, C_MIN}, 1'b0},
    '{'{2'd0, 2'd3, 16'hFFFF}, '{-24'sd1, -24'sd1, -24'sd1, -24'sd1}, 1'b0},
    '{'{2'd1, 2'd2, 16'h1FFF}, '{24'sd0, 24'sh123456, -24'sh123456, 24'sd0}, 1'b0},
    '{'{2'd1, 2'd2, 16'h2000}, '{24'sd0, 24'sh123456, -24'sh123456, 24'sd0}, 1'b0},
    '{'{2'd2, 2'd0, 16'h6000}, '{C_MAX, 24'sd1, C_MIN, 24'sd2}, 1'b0},
    '{'{2'd3, 2'd1, 16'hA000}, '{24'sh0ABCDE, -24'sh0ABCDE, 24'sh055555, -24'sh2AAAAA},
      1'b0},
    '{'{2'd2, 2'd2, 16'h4000}, '{C_MAX, C_MIN, -24'sd1, 24'sh123456}, 1'b1},
    '{'{2'd3, 2'd3, 16'hFFFF}, '{C_MIN, C_MIN, C_MAX, C_MAX}, 1'b1},
    '{'{2'd0, 2'd0, 16'h0000}, '{24'sd1, 24'sd2, 24'sd3, 24'sd4}, 1'b1},
    '{'{2'd1, 2'd3, 16'h1234}, '{24'sd0, 24'sd0, 24'sd0, 24'sd0}, 1'b1},
    '{'{2'd1, 2'd3, 16'hE000}, '{24'sh400000, -24'sh400000, 24'sh3FFFFF, -24'sh400001},
      1'b0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  pr4d_in_if  pnt_if ();
  pr4d_out_if rot_if ();

  plane_rotation_4d_point_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pnt_i   (pnt_if),
    .rot_o   (rot_if)
  );

  // Rotated words still owed by the block, oldest first
  rot_word_t   rotated_due [$];
  pr4d_cfg_t   cfg_now;          // plane setting the block should hold now

  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned points_sent;
  int unsigned words_checked;
  int unsigned clipped_words;
  int unsigned settings_loaded;
  int unsigned in_stall_cycles;

  // Source and sink pacing; hold_left and stall_left are owned by the sink process below
  bit          sender_free;
  bit          receiver_free;
  bit          hold_request;
  int unsigned hold_left;
  int unsigned stall_left;

  always begin
    clk_i = 1'b0;
    #(HALF_PERIOD);
    clk_i = 1'b1;
    #(HALF_PERIOD);
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Apply the 1/K gain with round-half-up, then saturate to Q15.8.
  function automatic pr4d_coord_t gain_clamp(input longint v, inout logic clip);
    longint r;
    r = (v * GAIN_K + (longint'(1) <<< 37)) >>> 38;
    if (r > longint'(C_MAX)) begin
      clip = 1'b1;
      r = C_MAX;
    end else if (r < longint'(C_MIN)) begin
      clip = 1'b1;
      r = C_MIN;
    end
    return pr4d_coord_t'(r);
  endfunction

  // Rotate the point in the (plane_first, plane_second) plane: exact quarter
  // turns first, then the CORDIC micro-rotations on the residual angle.
  function automatic rot_word_t rotate_point(input point_t pt, input pr4d_cfg_t cfg);
    rot_word_t          res;
    logic [ANGLE_W-1:0] shifted;
    longint             x, y, z, t, dx, dy;
    int                 a, b;
    logic               clip;
    res.crd = pt;
    res.clip = 1'b0;
    for (int k = DIM; k < NCOORD; k++) res.crd[k] = '0;
    a = cfg.plane_first;
    b = cfg.plane_second;
    if (a == b || a >= DIM || b >= DIM) return res;

    shifted = cfg.turn_angle + ANGLE_W'(8192);
    z = (longint'(shifted[13:0]) - 8192) * 65536;
    x = longint'($signed(pt[a]));
    y = longint'($signed(pt[b]));
    case (shifted[15:14])
      2'd1: begin
        t = x;
        x = -y;
        y = t;
      end
      2'd2: begin
        x = -x;
        y = -y;
      end
      2'd3: begin
        t = x;
        x = y;
        y = -t;
      end
      default: ;
    endcase
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURN[i];
      end
    end
    clip = 1'b0;
    res.crd[a] = gain_clamp(x, clip);
    res.crd[b] = gain_clamp(y, clip);
    res.clip = clip;
    return res;
  endfunction

  // Mostly full-range values, with small magnitudes and the extremes mixed in
  function automatic pr4d_coord_t random_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return '0;
          3:       return -24'sd1;
          default: return 24'sd1;
        endcase
      end
      1, 2:    return pr4d_coord_t'(int'($urandom_range(0, 8191)) - 4096);
      default: return pr4d_coord_t'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port. Each task starts and ends at a falling edge.
  // --------------------------------------------------------------------------

  task automatic reg_write(input logic [AXIS_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read(input logic [AXIS_W-1:0] idx, input logic [DATA_W-1:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $error("prdata[reg %0d]: expected %0h, got %0h", idx, want, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Load a plane setting; with noisy set, pad the unused data bits with junk
  // and poke the unmapped slot, then read everything back.
  task automatic program_plane(input pr4d_cfg_t cfg, input bit noisy);
    logic [DATA_W-1:0] pad;
    pad = noisy ? DATA_W'($urandom) : '0;
    reg_write(REG_PLANE_FIRST, {pad[DATA_W-1:AXIS_W], cfg.plane_first});
    pad = noisy ? DATA_W'($urandom) : '0;
    reg_write(REG_PLANE_SECOND, {pad[DATA_W-1:AXIS_W], cfg.plane_second});
    pad = noisy ? DATA_W'($urandom) : '0;
    reg_write(REG_TURN_ANGLE, {pad[DATA_W-1:ANGLE_W], cfg.turn_angle});
    if (noisy) reg_write(REG_SPARE, DATA_W'($urandom));
    cfg_now = cfg;
    settings_loaded++;
    reg_read(REG_PLANE_FIRST, DATA_W'(cfg.plane_first));
    reg_read(REG_PLANE_SECOND, DATA_W'(cfg.plane_second));
    reg_read(REG_TURN_ANGLE, DATA_W'(cfg.turn_angle));
  endtask

  // --------------------------------------------------------------------------
  // Point source. Entered at a falling edge; valid stays high after a word
  // unless the next draw asks for a gap, so it is never dropped and raised
  // in the same step.
  // --------------------------------------------------------------------------

  task automatic send_point(input point_t pt, input logic unchanged);
    int        gap;
    rot_word_t want;
    gap = sender_free ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      pnt_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pnt_if.valid   <= 1'b1;
    pnt_if.coord_0 <= pt[0];
    pnt_if.coord_1 <= pt[1];
    pnt_if.coord_2 <= pt[2];
    pnt_if.coord_3 <= pt[3];
    do @(posedge clk_i); while (!pnt_if.ready);
    // Word taken at this edge: log what must come back for it
    if (unchanged) begin
      want.crd  = pt;
      want.clip = 1'b0;
    end else begin
      want = rotate_point(pt, cfg_now);
    end
    rotated_due.push_back(want);
    points_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every owed word has come back.
  task automatic wait_rotated_drained();
    pnt_if.valid <= 1'b0;
    do @(posedge clk_i); while (rotated_due.size() != 0);
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result sink: check each accepted word against the oldest expectation and
  // pace ready. A long hold is counted here once the stimulus asks for it.
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    rot_word_t got;
    rot_word_t want;
    logic      accepted;
    accepted = rst_ni && rot_if.valid && rot_if.ready;
    if (pnt_if.valid && !pnt_if.ready) in_stall_cycles++;

    if (accepted) begin
      got.crd[0] = rot_if.rotated_0;
      got.crd[1] = rot_if.rotated_1;
      got.crd[2] = rot_if.rotated_2;
      got.crd[3] = rot_if.rotated_3;
      got.clip   = rot_if.clipped;
      if (rotated_due.size() == 0) begin
        $error("rotated word arrived with no point outstanding");
        mismatches++;
      end else begin
        want = rotated_due.pop_front();
        for (int k = 0; k < NCOORD; k++) begin
          if (got.crd[k] !== want.crd[k]) begin
            $error("rotated_%0d: expected %0d, got %0d", k,
                   $signed(want.crd[k]), $signed(got.crd[k]));
            mismatches++;
          end
        end
        if (got.clip !== want.clip) begin
          $error("clipped: expected %0b, got %0b", want.clip, got.clip);
          mismatches++;
        end
        words_checked++;
        if (got.clip) clipped_words++;
      end
    end

    // Start the long hold on request, otherwise count it down
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left--;
    end

    // Draw a fresh stall per word; run the stall down only outside a hold
    if (accepted) begin
      stall_left = receiver_free ? 0 : $urandom_range(0, MAX_GAP);
    end else if (stall_left > 0 && hold_left == 0) begin
      stall_left--;
    end
  end

  always @(negedge clk_i) begin
    rot_if.ready <= (hold_left == 0) && (stall_left == 0);
  end

  // Hard stop: a hung handshake must not run forever
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  initial begin
    pr4d_cfg_t cfg;
    point_t    pt;

    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    pnt_if.valid   = 1'b0;
    pnt_if.coord_0 = '0;
    pnt_if.coord_1 = '0;
    pnt_if.coord_2 = '0;
    pnt_if.coord_3 = '0;
    rot_if.ready   = 1'b0;
    cfg_now        = '{2'd0, 2'd1, 16'h0000};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Registers must come out of reset as plane (0, 1), angle 0
    reg_read(REG_PLANE_FIRST, DATA_W'(0));
    reg_read(REG_PLANE_SECOND, DATA_W'(1));
    reg_read(REG_TURN_ANGLE, DATA_W'(0));

    // Walk the directed table; reprogram only when the plane setting changes
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      if (DIRECTED[r].cfg != cfg_now) begin
        wait_rotated_drained();
        program_plane(DIRECTED[r].cfg, 1'b0);
      end
      send_point(DIRECTED[r].pt, DIRECTED[r].unchanged);
    end

    // Random batches, each under its own plane setting. The first few pin
    // the extremes: zero angle, top angle with the top axes, equal axes,
    // half turn, and an octant boundary.
    for (int n = 0; n < NUM_BATCHES; n++) begin
      wait_rotated_drained();
      cfg.plane_first  = AXIS_W'($urandom_range(0, 3));
      cfg.plane_second = AXIS_W'($urandom_range(0, 3));
      cfg.turn_angle   = ANGLE_W'($urandom);
      case (n)
        0:       cfg = '{2'd0, 2'd1, 16'h0000};
        1:       cfg = '{2'd3, 2'd2, 16'hFFFF};
        2:       cfg.plane_second = cfg.plane_first;
        3:       cfg = '{2'd0, 2'd3, 16'h8000};
        4:       cfg.turn_angle = 16'h2000;
        default: ;
      endcase
      if (n >= 5 && cfg.plane_first == cfg.plane_second)
        cfg.plane_second = cfg.plane_first + 2'd1;
      program_plane(cfg, 1'b1);

      sender_free   = (n == BURST_BATCH) || (n == FREE_BATCH);
      receiver_free = (n == FREE_BATCH);
      // Flood the block while the sink stops, so the pipe fills and stalls
      if (n == BURST_BATCH) hold_request = 1'b1;

      for (int i = 0; i < BATCH_POINTS; i++) begin
        for (int k = 0; k < NCOORD; k++) pt[k] = random_coord();
        send_point(pt, 1'b0);
      end
    end

    wait_rotated_drained();
    // Give any stray word time to surface
    repeat (LATENCY + 5) @(posedge clk_i);

    $display("Run: %0d points (%0d directed) under %0d plane settings, %0d words checked.",
             points_sent, NUM_DIRECTED, settings_loaded, words_checked);
    $display("Saturated words: %0d; input held off for %0d cycles behind the sink.",
             clipped_words, in_stall_cycles);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
hdl/pr4d_pkg.sv
hdl/pr4d_ifs.sv
hdl/pr4d_cfg.sv
hdl/pr4d_front.sv
hdl/pr4d_queue.sv
hdl/pr4d_back.sv
hdl/plane_rotation_4d_point_top.sv
hdl/pr4d_chk.sv
test/tb_plane_rotation_4d_point_top.sv
